>>> src/lbct_pkg.sv
// lbct_pkg: types and constants shared by the LRU block cache tag engine.
// Request and response structs, command codes, scan summary struct.
// No dependencies.
package lbct_pkg;

    localparam int TAG_W  = 32;
    localparam int AGE_W  = 32;
    localparam int CFG_W  = 4;
    localparam int SLOT_W = 6;   // wide enough for the largest built slot count

    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_INVAL  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef logic [2:0]        out_idx_t;
    typedef logic [SLOT_W-1:0] slot_idx_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [TAG_W-1:0] block_number;
        logic             device_failed;
    } req_t;

    typedef struct packed {
        logic     hit;
        out_idx_t slot_index;
        logic     fill;
        logic     status;
    } rsp_t;

    typedef struct packed {
        logic      match_found;
        slot_idx_t match_idx;
        logic      inv_found;
        slot_idx_t inv_idx;
        slot_idx_t min_idx;
    } scan_sum_t;

endpackage

>>> src/lbct_store.sv
// lbct_store: tag and age memories of the cache slots.
// One write port, one registered read port. Uses lbct_pkg.
module lbct_store #(
    parameter int DEPTH = 8,
    parameter int IDX_W = 3
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [IDX_W-1:0]          waddr,
    input  logic [lbct_pkg::TAG_W-1:0] wtag,
    input  logic [lbct_pkg::AGE_W-1:0] wage,
    input  logic [IDX_W-1:0]          raddr,
    output logic [lbct_pkg::TAG_W-1:0] rtag,
    output logic [lbct_pkg::AGE_W-1:0] rage
);
    import lbct_pkg::*;

    logic [TAG_W-1:0] tag_mem [DEPTH];
    logic [AGE_W-1:0] age_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            tag_mem[waddr] <= wtag;
            age_mem[waddr] <= wage;
        end
    end

    always_ff @(posedge clk)
    begin
        rtag <= tag_mem[raddr];
        rage <= age_mem[raddr];
    end

endmodule

>>> src/lbct_scan.sv
// lbct_scan: shared compare unit, one slot per cycle while cmp_vld is high.
// Tracks first tag match, first invalid slot and oldest slot. Uses lbct_pkg.
module lbct_scan #(
    parameter int IDX_W = 3
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic                       cmp_vld,
    input  logic [IDX_W-1:0]           cmp_idx,
    input  logic                       slot_valid,
    input  logic [lbct_pkg::TAG_W-1:0] tag,
    input  logic [lbct_pkg::TAG_W-1:0] key,
    input  logic [lbct_pkg::AGE_W-1:0] age,
    output lbct_pkg::scan_sum_t        sum
);
    import lbct_pkg::*;

    logic             match_found_reg, match_found_next;
    logic             inv_found_reg, inv_found_next;
    slot_idx_t        match_idx_reg, match_idx_next;
    slot_idx_t        inv_idx_reg, inv_idx_next;
    slot_idx_t        min_idx_reg, min_idx_next;
    logic [AGE_W-1:0] min_age_reg, min_age_next;

    always_comb
    begin
        match_found_next = match_found_reg;
        inv_found_next   = inv_found_reg;
        match_idx_next   = match_idx_reg;
        inv_idx_next     = inv_idx_reg;
        min_idx_next     = min_idx_reg;
        min_age_next     = min_age_reg;
        if (clear)
        begin
            match_found_next = 1'b0;
            inv_found_next   = 1'b0;
        end
        else if (cmp_vld)
        begin
            if (slot_valid && (tag == key) && !match_found_reg)
            begin
                match_found_next = 1'b1;
                match_idx_next   = slot_idx_t'(cmp_idx);
            end
            if (!slot_valid && !inv_found_reg)
            begin
                inv_found_next = 1'b1;
                inv_idx_next   = slot_idx_t'(cmp_idx);
            end
            if ((cmp_idx == '0) || (age < min_age_reg))
            begin
                min_age_next = age;
                min_idx_next = slot_idx_t'(cmp_idx);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg <= 1'b0;
            inv_found_reg   <= 1'b0;
        end
        else
        begin
            match_found_reg <= match_found_next;
            inv_found_reg   <= inv_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_idx_reg <= match_idx_next;
        inv_idx_reg   <= inv_idx_next;
        min_idx_reg   <= min_idx_next;
        min_age_reg   <= min_age_next;
    end

    assign sum.match_found = match_found_reg;
    assign sum.match_idx   = match_idx_reg;
    assign sum.inv_found   = inv_found_reg;
    assign sum.inv_idx     = inv_idx_reg;
    assign sum.min_idx     = min_idx_reg;

endmodule

>>> src/lru_block_cache_tags.sv
// lru_block_cache_tags: LRU tag engine, top level. Uses lbct_pkg, lbct_store, lbct_scan.
// Read or successful write: done pulses N+3 cycles after the start transfer,
// N = enabled slots; one tag/age memory read per cycle through the shared compare unit.
// Invalidate, failed write, unused command: done pulses the cycle after the transfer.
// A new start is taken in the cycle done is shown; done cannot be stalled.
// Reset: valid bits cleared, use clock zero, slot count 8; tag/age memories not cleared.
module lru_block_cache_tags #(
    parameter int MAX_SLOTS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  lbct_pkg::req_t             req,
    output logic                       done,
    output lbct_pkg::rsp_t             rsp,
    input  logic                       cfg_we,
    input  logic [lbct_pkg::CFG_W-1:0] cfg_wdata
);
    import lbct_pkg::*;

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_UPD   = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic                 done_reg, done_next;
    logic [MAX_SLOTS-1:0] valid_reg, valid_next;
    logic [AGE_W-1:0]     clock_reg, clock_next;
    logic [CFG_W-1:0]     slots_reg;
    logic                 cmp_vld_reg;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic [IDX_W-1:0]     rd_addr_reg, rd_addr_next;
    req_t                 req_reg, req_next;
    rsp_t                 rsp_reg, rsp_next;

    logic                 acc;
    logic [IDX_W-1:0]     last_idx;
    logic [AGE_W-1:0]     tick;
    logic [IDX_W-1:0]     upd_idx;
    logic                 mem_we;
    logic [TAG_W-1:0]     rd_tag;
    logic [AGE_W-1:0]     rd_age;
    scan_sum_t            sum;

    assign busy = (state_reg != ST_IDLE);
    assign acc  = start && !busy;
    assign tick = clock_reg + 1'b1;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    always_comb
    begin
        if ((slots_reg == '0) || (int'(slots_reg) > MAX_SLOTS))
            last_idx = IDX_W'(MAX_SLOTS - 1);
        else
            last_idx = IDX_W'(slots_reg - 1'b1);
    end

    always_comb
    begin
        if (sum.match_found)
            upd_idx = sum.match_idx[IDX_W-1:0];
        else if (sum.inv_found)
            upd_idx = sum.inv_idx[IDX_W-1:0];
        else
            upd_idx = sum.min_idx[IDX_W-1:0];
    end

    always_comb
    begin
        state_next   = state_reg;
        done_next    = 1'b0;
        valid_next   = valid_reg;
        clock_next   = clock_reg;
        rd_addr_next = rd_addr_reg;
        req_next     = req_reg;
        rsp_next     = rsp_reg;
        mem_we       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    req_next     = req;
                    rd_addr_next = '0;
                    if ((req.cmd == CMD_READ) || ((req.cmd == CMD_WRITE) && !req.device_failed))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        rsp_next   = '0;
                        rsp_next.status = (req.cmd == CMD_WRITE);
                        if (req.cmd == CMD_INVAL)
                        begin
                            valid_next = '0;
                            clock_next = '0;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                rd_addr_next = rd_addr_reg + 1'b1;
                if (rd_addr_reg == last_idx)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                rsp_next   = '0;
                if (sum.match_found)
                begin
                    mem_we              = 1'b1;
                    clock_next          = tick;
                    rsp_next.hit        = 1'b1;
                    rsp_next.slot_index = out_idx_t'(upd_idx);
                end
                else if (req_reg.cmd == CMD_READ)
                begin
                    if (req_reg.device_failed)
                    begin
                        rsp_next.status = 1'b1;
                    end
                    else
                    begin
                        mem_we              = 1'b1;
                        clock_next          = tick;
                        valid_next[upd_idx] = 1'b1;
                        rsp_next.fill       = 1'b1;
                        rsp_next.slot_index = out_idx_t'(upd_idx);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            done_reg    <= 1'b0;
            valid_reg   <= '0;
            clock_reg   <= '0;
            slots_reg   <= CFG_RESET;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            valid_reg   <= valid_next;
            clock_reg   <= clock_next;
            cmp_vld_reg <= (state_reg == ST_SCAN);
            if (cfg_we)
                slots_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr_next;
        cmp_idx_reg <= rd_addr_reg;
        req_reg     <= req_next;
        rsp_reg     <= rsp_next;
    end

    lbct_store #(
        .DEPTH (MAX_SLOTS),
        .IDX_W (IDX_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (upd_idx),
        .wtag  (req_reg.block_number),
        .wage  (tick),
        .raddr (rd_addr_reg),
        .rtag  (rd_tag),
        .rage  (rd_age)
    );

    lbct_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (acc),
        .cmp_vld    (cmp_vld_reg),
        .cmp_idx    (cmp_idx_reg),
        .slot_valid (valid_reg[cmp_idx_reg]),
        .tag        (rd_tag),
        .key        (req_reg.block_number),
        .age        (rd_age),
        .sum        (sum)
    );

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_UPD) || $past(acc))
        else $error("done without a finished request");

    a_fill_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.fill) |-> (!rsp.hit && !rsp.status))
        else $error("fill together with hit or error");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status) |-> (!rsp.hit && !rsp.fill && (rsp.slot_index == '0)))
        else $error("error response carries slot data");

    a_inval: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (req.cmd == CMD_INVAL)) |=> ((valid_reg == '0) && (clock_reg == '0)))
        else $error("invalidate did not clear state");

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !done)
        else $error("response while scanning");

endmodule

>>> bench/lbct_lru_checker.sv
`timescale 1ns / 100ps
// lbct_lru_checker: monitors the request, response and config ports of
// lru_block_cache_tags, predicts each response with its own LRU tag model and
// compares it field by field. Depends on lbct_pkg.
module lbct_lru_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  lbct_pkg::req_t             req,
    input  logic                       done,
    input  lbct_pkg::rsp_t             rsp,
    input  logic                       cfg_we,
    input  logic [lbct_pkg::CFG_W-1:0] cfg_wdata,
    output int                         fail_count,
    output int                         pending
);
    import lbct_pkg::*;

    localparam int NSLOT = 8;

    logic [TAG_W-1:0] tag_mem [NSLOT];
    logic [AGE_W-1:0] age_mem [NSLOT];
    logic [NSLOT-1:0] valid_bits;
    logic [AGE_W-1:0] use_clock;
    logic [CFG_W-1:0] slots_cfg;
    rsp_t             rsp_due_q[$];

    function automatic int enabled_slots();
        if (slots_cfg == 0 || slots_cfg > NSLOT)
            return NSLOT;
        return int'(slots_cfg);
    endfunction

    function automatic void touch_slot(input int s);
        use_clock  = use_clock + 1'b1;
        age_mem[s] = use_clock;
    endfunction

    function automatic int pick_victim(input int n);
        int i;
        int best;
        best = 0;
        for (i = 0; i < n; i++)
        begin
            if (!valid_bits[i])
                return i;
        end
        for (i = 1; i < n; i++)
        begin
            if (age_mem[i] < age_mem[best])
                best = i;
        end
        return best;
    endfunction

    // Applies one request to the tag model and returns the response it owes.
    function automatic rsp_t lru_lookup(input req_t r);
        rsp_t o;
        int   n;
        int   i;
        int   hit_at;
        int   victim;
        o      = '0;
        n      = enabled_slots();
        hit_at = -1;
        for (i = n - 1; i >= 0; i--)
        begin
            if (valid_bits[i] && tag_mem[i] == r.block_number)
                hit_at = i;
        end
        case (r.cmd)
            CMD_READ:
            begin
                if (hit_at >= 0)
                begin
                    touch_slot(hit_at);
                    o.hit        = 1'b1;
                    o.slot_index = out_idx_t'(hit_at);
                end
                else if (r.device_failed)
                    o.status = 1'b1;
                else
                begin
                    victim              = pick_victim(n);
                    tag_mem[victim]     = r.block_number;
                    valid_bits[victim]  = 1'b1;
                    touch_slot(victim);
                    o.fill       = 1'b1;
                    o.slot_index = out_idx_t'(victim);
                end
            end
            CMD_WRITE:
            begin
                if (r.device_failed)
                    o.status = 1'b1;
                else if (hit_at >= 0)
                begin
                    touch_slot(hit_at);
                    o.hit        = 1'b1;
                    o.slot_index = out_idx_t'(hit_at);
                end
            end
            CMD_INVAL:
            begin
                valid_bits = '0;
                use_clock  = '0;
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic void check_field(input string name, input logic [3:0] want,
                                        input logic [3:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        int   i;
        if (!rst_n)
        begin
            valid_bits = '0;
            use_clock  = '0;
            slots_cfg  = CFG_RESET;
            for (i = 0; i < NSLOT; i++)
            begin
                tag_mem[i] = '0;
                age_mem[i] = '0;
            end
            rsp_due_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (done)
            begin
                if (rsp_due_q.size() == 0)
                begin
                    $error("response transfer with no request outstanding: %p", rsp);
                    fail_count++;
                end
                else
                begin
                    want = rsp_due_q.pop_front();
                    check_field("hit", 4'(want.hit), 4'(rsp.hit));
                    check_field("slot_index", 4'(want.slot_index), 4'(rsp.slot_index));
                    check_field("fill", 4'(want.fill), 4'(rsp.fill));
                    check_field("status", 4'(want.status), 4'(rsp.status));
                end
            end
            if (cfg_we)
                slots_cfg = cfg_wdata;
            if (start && !busy)
                rsp_due_q.push_back(lru_lookup(req));
        end
        pending = rsp_due_q.size();
    end

endmodule

>>> bench/lru_block_cache_tags_tb.sv
`timescale 1ns / 100ps
// lru_block_cache_tags_tb: drives directed and random cache requests and slot
// count settings into lru_block_cache_tags; lbct_lru_checker does the checking.
// Depends on lbct_pkg, lru_block_cache_tags and lbct_lru_checker.
module lru_block_cache_tags_tb;
    import lbct_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int NPHASE      = 14;
    localparam int PHASE_ITEMS = 136;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    req_t             req;
    logic             done;
    rsp_t             rsp;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    int               fail_count;
    int               pending;
    int               cycles;

    logic [TAG_W-1:0] tag_pool [16];
    int               pool_n;

    lru_block_cache_tags u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    lbct_lru_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .rsp        (rsp),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Holds start high until the request transfer happens and busy is low again.
    task automatic issue(input logic [1:0] c, input logic [TAG_W-1:0] b, input logic f);
        req_t r;
        r.cmd           = c;
        r.block_number  = b;
        r.device_failed = f;
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
    endtask

    task automatic idle(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic set_slots(input logic [CFG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [TAG_W-1:0] pick_block();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return tag_pool[$urandom_range(0, pool_n - 1)];
        if (r < 93)
            return $urandom;
        return r[0] ? '1 : '0;
    endfunction

    function automatic logic [1:0] pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 58)
            return CMD_READ;
        if (r < 91)
            return CMD_WRITE;
        if (r < 97)
            return CMD_INVAL;
        return CMD_UNUSED;
    endfunction

    initial
    begin
        logic [CFG_W-1:0] phase_cfg [NPHASE];
        int               ph;
        int               i;
        int               k;
        int               burst;
        phase_cfg = '{4'd3, 4'd8, 4'd1, 4'd0, 4'd15, 4'd2, 4'd5, 4'd8,
                      4'd6, 4'd9, 4'd4, 4'd7, 4'd1, 4'd8};
        rst_n     = 1'b0;
        start     <= 1'b0;
        req       <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fills, hits, failures, eviction, invalidate, unused command
        issue(CMD_READ, 32'h0000_0000, 1'b0);
        issue(CMD_READ, 32'hFFFF_FFFF, 1'b0);
        issue(CMD_READ, 32'h0000_0000, 1'b0);
        issue(CMD_READ, 32'h0000_0000, 1'b1);
        issue(CMD_WRITE, 32'hFFFF_FFFF, 1'b0);
        issue(CMD_WRITE, 32'h0000_0000, 1'b1);
        issue(CMD_WRITE, 32'h1234_5678, 1'b0);
        issue(CMD_READ, 32'h5555_5555, 1'b1);
        for (k = 0; k < 7; k++)
            issue(CMD_READ, 32'hAAAA_AAA0 + k, 1'b0);
        issue(CMD_READ, 32'h0000_0000, 1'b0);
        issue(CMD_INVAL, 32'hFFFF_FFFF, 1'b1);
        issue(CMD_UNUSED, 32'h0000_0000, 1'b1);
        issue(CMD_READ, 32'hFFFF_FFFF, 1'b0);
        drain();
        set_slots(4'd1);
        issue(CMD_READ, 32'h8000_0001, 1'b0);
        issue(CMD_READ, 32'h7FFF_FFFE, 1'b0);
        issue(CMD_READ, 32'h7FFF_FFFE, 1'b0);
        issue(CMD_WRITE, 32'h8000_0001, 1'b0);

        for (ph = 0; ph < NPHASE; ph++)
        begin
            drain();
            set_slots(ph < 8 ? phase_cfg[ph] : CFG_W'($urandom_range(0, 15)));
            pool_n = $urandom_range(2, 14);
            for (i = 0; i < 16; i++)
                tag_pool[i] = (i == 0 && ph[0]) ? '0 : (i == 1 && ph[1]) ? '1 : $urandom;
            k = 0;
            while (k < PHASE_ITEMS)
            begin
                burst = $urandom_range(1, 24);
                for (i = 0; i < burst && k < PHASE_ITEMS; i++)
                begin
                    issue(pick_cmd(), pick_block(), $urandom_range(0, 99) < 15);
                    k++;
                end
                if ($urandom_range(0, 19) == 0)
                    drain();
                else if ($urandom_range(0, 3) != 0)
                    idle($urandom_range(1, 12));
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
